### hdl/legik_pkg.sv
// ----------------------------------------------------------------------------
// legik_pkg
// Shared types, constants and angle table for the two-link leg IK pipeline.
// ----------------------------------------------------------------------------
package legik_pkg;

  // angle / CORDIC datapath width (Q30 radians, signed)
  localparam int ANG_W = 34;
  // quotient bits of the cosine divide (Q30)
  localparam int QW    = 30;

  localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [31:0]      ONE_Q30     = 32'sd1073741824;

  // output saturation limits (2^-16 rad)
  localparam logic signed [21:0] KNEE_MAX = 22'sd205887;
  localparam logic signed [21:0] HIP_MIN  = -22'sd205887;
  localparam logic signed [21:0] HIP_MAX  = 22'sd411775;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_THIGH_LEN = 1'b0,
    CFG_SHANK_LEN = 1'b1
  } cfg_idx_t;

  // CORDIC vector handed from cell to cell
  typedef struct packed {
    logic signed [ANG_W-1:0] xv;
    logic signed [ANG_W-1:0] yv;
    logic signed [ANG_W-1:0] z;
  } cordic_vec_t;

  // atan(2^-i) in Q30, rounded
  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ANG_W-1:0] a;
    case (idx)
      5'd0:    a = 34'sd843314857;
      5'd1:    a = 34'sd497837830;
      5'd2:    a = 34'sd263043837;
      5'd3:    a = 34'sd133525159;
      5'd4:    a = 34'sd67021687;
      5'd5:    a = 34'sd33543516;
      5'd6:    a = 34'sd16775851;
      5'd7:    a = 34'sd8388437;
      5'd8:    a = 34'sd4194283;
      5'd9:    a = 34'sd2097149;
      5'd10:   a = 34'sd1048576;
      5'd11:   a = 34'sd524288;
      5'd12:   a = 34'sd262144;
      5'd13:   a = 34'sd131072;
      5'd14:   a = 34'sd65536;
      5'd15:   a = 34'sd32768;
      5'd16:   a = 34'sd16384;
      5'd17:   a = 34'sd8192;
      5'd18:   a = 34'sd4096;
      5'd19:   a = 34'sd2048;
      5'd20:   a = 34'sd1024;
      5'd21:   a = 34'sd512;
      5'd22:   a = 34'sd256;
      5'd23:   a = 34'sd128;
      5'd24:   a = 34'sd64;
      5'd25:   a = 34'sd32;
      5'd26:   a = 34'sd16;
      5'd27:   a = 34'sd8;
      5'd28:   a = 34'sd4;
      5'd29:   a = 34'sd2;
      5'd30:   a = 34'sd1;
      default: a = 34'sd0;
    endcase
    return a;
  endfunction

  // quadrant pre-rotation by +-pi/2 when x is negative
  function automatic cordic_vec_t cordic_prep(input logic signed [ANG_W-1:0] ya,
                                              input logic signed [ANG_W-1:0] xa);
    cordic_vec_t v;
    v.xv = xa;
    v.yv = ya;
    v.z  = '0;
    if (xa[ANG_W-1]) begin
      if (!ya[ANG_W-1]) begin
        v.xv = ya;
        v.yv = -xa;
        v.z  = HALF_PI_Q30;
      end else begin
        v.xv = -ya;
        v.yv = xa;
        v.z  = -HALF_PI_Q30;
      end
    end
    return v;
  endfunction

endpackage

### hdl/legik_sqrt_cell.sv
// ----------------------------------------------------------------------------
// legik_sqrt_cell
// One digit step of a restoring integer square root, registered.
// ----------------------------------------------------------------------------
module legik_sqrt_cell import legik_pkg::*; #(
  parameter int RAD_W = 42,
  parameter int PW    = 1
) (
  input  logic                   clk,
  input  logic [RAD_W-1:0]       rad_in,
  input  logic [RAD_W/2+1:0]     rem_in,
  input  logic [RAD_W/2-1:0]     root_in,
  input  logic [PW-1:0]          pass_in,
  output logic [RAD_W-1:0]       rad_r,
  output logic [RAD_W/2+1:0]     rem_r,
  output logic [RAD_W/2-1:0]     root_r,
  output logic [PW-1:0]          pass_r
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  logic [REM_W:0]   cand;
  logic [REM_W:0]   trial;
  logic [REM_W:0]   diff;
  logic             ge;
  logic [REM_W-1:0] rem_nxt;

  // bring down two radicand bits, try subtracting 4*root+1
  assign cand  = {rem_in[REM_W-2:0], rad_in[RAD_W-1 -: 2]};
  assign trial = {1'b0, root_in, 2'b01};
  assign diff  = cand - trial;
  assign ge    = (cand >= trial);
  assign rem_nxt = ge ? diff[REM_W-1:0] : cand[REM_W-1:0];

  always_ff @(posedge clk) begin
    rad_r  <= {rad_in[RAD_W-3:0], 2'b00};
    rem_r  <= rem_nxt;
    root_r <= {root_in[ROOT_W-2:0], ge};
    pass_r <= pass_in;
  end

endmodule

### hdl/legik_div_cell.sv
// ----------------------------------------------------------------------------
// legik_div_cell
// One quotient bit of a restoring unsigned divide, registered.
// ----------------------------------------------------------------------------
module legik_div_cell import legik_pkg::*; #(
  parameter int DW = 41,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic [DW-1:0] den_in,
  input  logic [DW-1:0] rem_in,
  input  logic [QW-1:0] quo_in,
  input  logic [PW-1:0] pass_in,
  output logic [DW-1:0] den_r,
  output logic [DW-1:0] rem_r,
  output logic [QW-1:0] quo_r,
  output logic [PW-1:0] pass_r
);

  logic [DW:0] r2;
  logic [DW:0] diff;
  logic        ge;

  // shift remainder, subtract divisor when it fits
  assign r2   = {rem_in, 1'b0};
  assign diff = r2 - {1'b0, den_in};
  assign ge   = (r2 >= {1'b0, den_in});

  always_ff @(posedge clk) begin
    den_r  <= den_in;
    rem_r  <= ge ? diff[DW-1:0] : r2[DW-1:0];
    quo_r  <= {quo_in[QW-2:0], ge};
    pass_r <= pass_in;
  end

endmodule

### hdl/legik_cordic_cell.sv
// ----------------------------------------------------------------------------
// legik_cordic_cell
// One vectoring CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module legik_cordic_cell import legik_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  logic        clk,
  input  cordic_vec_t vec_in,
  output cordic_vec_t vec_r
);

  logic signed [ANG_W-1:0] xv;
  logic signed [ANG_W-1:0] yv;
  logic signed [ANG_W-1:0] dx;
  logic signed [ANG_W-1:0] dy;
  logic signed [ANG_W-1:0] ang;
  cordic_vec_t             vec_nxt;

  assign xv  = vec_in.xv;
  assign yv  = vec_in.yv;
  assign dx  = yv >>> STAGE;
  assign dy  = xv >>> STAGE;
  assign ang = atan_q30(STAGE[4:0]);

  // rotate toward the x axis
  always_comb begin
    if (!yv[ANG_W-1]) begin
      vec_nxt.xv = xv + dx;
      vec_nxt.yv = yv - dy;
      vec_nxt.z  = vec_in.z + ang;
    end else begin
      vec_nxt.xv = xv - dx;
      vec_nxt.yv = yv + dy;
      vec_nxt.z  = vec_in.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    vec_r <= vec_nxt;
  end

endmodule

### hdl/two_link_leg_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// two_link_leg_inverse_kinematics
// Planar two-link leg IK: foot target (x, y) to hip and knee angles.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with in_foot_x / in_foot_y (micrometres, signed). A transaction
//   is taken on every edge with start high and busy low; busy is always low,
//   so a new target may be issued every cycle.
//   Each transaction gives one result: out_valid is high for one cycle with
//   out_hip_angle / out_knee_angle (2^-16 rad). The receiver cannot stall.
//   The datapath is a pipeline of chains of cells: 21 root digits for the
//   reach, 30 divide bits for the cosine terms, 31 root digits for the sine
//   terms and CORDIC_STAGES micro-rotations, plus 12 glue stages. Throughput
//   is one per cycle.
//   The user writes link lengths on the cfg_ port only while no transaction is
//   in flight; the block does not enforce this. Both reset to 200000 um.
//   Synchronous reset restores the default config and flushes pending transactions.
// ----------------------------------------------------------------------------
module two_link_leg_inverse_kinematics import legik_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [20:0] in_foot_x,
  input  logic signed [20:0] in_foot_y,
  output logic               out_valid,
  output logic signed [19:0] out_hip_angle,
  output logic        [17:0] out_knee_angle,
  input  logic               cfg_we,
  input  logic        [0:0]  cfg_index,
  input  logic        [18:0] cfg_wdata
);

  localparam int STAGES = 94 + CORDIC_STAGES;
  localparam int R1_W   = 42;           // reach radicand
  localparam int R1_RT  = R1_W / 2;
  localparam int R2_W   = 62;           // sine radicand
  localparam int R2_RT  = R2_W / 2;
  localparam int DW     = 41;

  logic acc;
  assign busy = 1'b0;
  assign acc  = start & ~busy;

  // --------------------------------------------------------------------------
  // configuration registers
  logic [18:0] thigh_r, thigh_nxt;
  logic [18:0] shank_r, shank_nxt;

  always_comb begin
    thigh_nxt = thigh_r;
    shank_nxt = shank_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_THIGH_LEN: thigh_nxt = cfg_wdata;
        CFG_SHANK_LEN: shank_nxt = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thigh_r <= 19'd200000;
      shank_r <= 19'd200000;
    end else begin
      thigh_r <= thigh_nxt;
      shank_r <= shank_nxt;
    end
  end

  // derived link terms, refreshed every cycle
  logic [18:0] t_eff, s_eff, t_s_d;
  logic [19:0] lo_nxt;
  logic signed [20:0] hi_raw;
  logic [37:0] tt_r, ss_r, ts_r;
  logic [19:0] lo_r, hi_r;

  assign t_eff  = (thigh_r == '0) ? 19'd1 : thigh_r;
  assign s_eff  = (shank_r == '0) ? 19'd1 : shank_r;
  assign t_s_d  = (t_eff > s_eff) ? (t_eff - s_eff) : (s_eff - t_eff);
  assign lo_nxt = {1'b0, t_s_d} + 20'd1000;
  assign hi_raw = $signed({2'b00, t_eff}) + $signed({2'b00, s_eff}) - 21'sd1000;

  always_ff @(posedge clk) begin
    tt_r <= t_eff * t_eff;
    ss_r <= s_eff * s_eff;
    ts_r <= t_eff * s_eff;
    lo_r <= lo_nxt;
    hi_r <= (hi_raw < $signed({1'b0, lo_nxt})) ? lo_nxt : hi_raw[19:0];
  end

  // --------------------------------------------------------------------------
  // transaction valid pipe
  logic [STAGES-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[STAGES-2:0], acc};
    end
  end

  // --------------------------------------------------------------------------
  // s1: squares of the target
  logic signed [41:0] xx_full, yy_full;
  logic [40:0] xx1_r, yy1_r;
  logic signed [20:0] x1_r, y1_r;

  assign xx_full = in_foot_x * in_foot_x;
  assign yy_full = in_foot_y * in_foot_y;

  always_ff @(posedge clk) begin
    xx1_r <= xx_full[40:0];
    yy1_r <= yy_full[40:0];
    x1_r  <= in_foot_x;
    y1_r  <= in_foot_y;
  end

  // s2: reach squared
  logic [R1_W-1:0] sq1_rad  [0:R1_RT];
  logic [R1_RT+1:0] sq1_rem [0:R1_RT];
  logic [R1_RT-1:0] sq1_root[0:R1_RT];
  logic [41:0]      sq1_pass[0:R1_RT];

  always_ff @(posedge clk) begin
    sq1_rad[0]  <= {1'b0, xx1_r} + {1'b0, yy1_r};
    sq1_rem[0]  <= '0;
    sq1_root[0] <= '0;
    sq1_pass[0] <= {x1_r, y1_r};
  end

  // reach root chain
  for (genvar k = 0; k < R1_RT; k++) begin : g_sq1
    legik_sqrt_cell #(.RAD_W(R1_W), .PW(42)) u_cell (
      .clk     (clk),
      .rad_in  (sq1_rad[k]),
      .rem_in  (sq1_rem[k]),
      .root_in (sq1_root[k]),
      .pass_in (sq1_pass[k]),
      .rad_r   (sq1_rad[k+1]),
      .rem_r   (sq1_rem[k+1]),
      .root_r  (sq1_root[k+1]),
      .pass_r  (sq1_pass[k+1])
    );
  end

  // s3: clamp reach
  logic [R1_RT-1:0] r0;
  logic [19:0] r3_r;
  logic [41:0] xy3_r;

  assign r0 = sq1_root[R1_RT];

  always_ff @(posedge clk) begin
    if (r0 < {1'b0, lo_r}) begin
      r3_r <= lo_r;
    end else if (r0 > {1'b0, hi_r}) begin
      r3_r <= hi_r;
    end else begin
      r3_r <= r0[19:0];
    end
    xy3_r <= sq1_pass[R1_RT];
  end

  // s4: r^2 and r*T
  logic [39:0] rsq4_r;
  logic [38:0] rt4_r;
  logic [41:0] xy4_r;

  always_ff @(posedge clk) begin
    rsq4_r <= r3_r * r3_r;
    rt4_r  <= r3_r * t_eff;
    xy4_r  <= xy3_r;
  end

  // s5: law-of-cosines numerators and denominators
  logic signed [41:0] nk5_r, np5_r;
  logic [DW-1:0] dk5_r, dp5_r;
  logic [41:0] xy5_r;

  always_ff @(posedge clk) begin
    nk5_r <= $signed({4'b0, tt_r}) + $signed({4'b0, ss_r}) - $signed({2'b0, rsq4_r});
    np5_r <= $signed({2'b0, rsq4_r}) + $signed({4'b0, tt_r}) - $signed({4'b0, ss_r});
    dk5_r <= {2'b0, ts_r, 1'b0};
    dp5_r <= {1'b0, rt4_r, 1'b0};
    xy5_r <= xy4_r;
  end

  // s6: saturation flags and magnitudes, start of divide chains
  logic signed [41:0] dks, dps;
  logic [41:0] nk_mag, np_mag;
  logic [DW-1:0] dvk_den [0:QW];
  logic [DW-1:0] dvk_rem [0:QW];
  logic [QW-1:0] dvk_quo [0:QW];
  logic [2:0]    dvk_pass[0:QW];
  logic [DW-1:0] dvp_den [0:QW];
  logic [DW-1:0] dvp_rem [0:QW];
  logic [QW-1:0] dvp_quo [0:QW];
  logic [44:0]   dvp_pass[0:QW];

  assign dks    = $signed({1'b0, dk5_r});
  assign dps    = $signed({1'b0, dp5_r});
  assign nk_mag = nk5_r[41] ? -nk5_r : nk5_r;
  assign np_mag = np5_r[41] ? -np5_r : np5_r;

  always_ff @(posedge clk) begin
    dvk_den[0]  <= dk5_r;
    dvk_rem[0]  <= nk_mag[DW-1:0];
    dvk_quo[0]  <= '0;
    dvk_pass[0] <= {nk5_r >= dks, nk5_r <= -dks, nk5_r[41]};
    dvp_den[0]  <= dp5_r;
    dvp_rem[0]  <= np_mag[DW-1:0];
    dvp_quo[0]  <= '0;
    dvp_pass[0] <= {xy5_r, np5_r >= dps, np5_r <= -dps, np5_r[41]};
  end

  // cosine divide chains
  for (genvar k = 0; k < QW; k++) begin : g_div
    legik_div_cell #(.DW(DW), .PW(3)) u_knee (
      .clk     (clk),
      .den_in  (dvk_den[k]),
      .rem_in  (dvk_rem[k]),
      .quo_in  (dvk_quo[k]),
      .pass_in (dvk_pass[k]),
      .den_r   (dvk_den[k+1]),
      .rem_r   (dvk_rem[k+1]),
      .quo_r   (dvk_quo[k+1]),
      .pass_r  (dvk_pass[k+1])
    );
    legik_div_cell #(.DW(DW), .PW(45)) u_hip (
      .clk     (clk),
      .den_in  (dvp_den[k]),
      .rem_in  (dvp_rem[k]),
      .quo_in  (dvp_quo[k]),
      .pass_in (dvp_pass[k]),
      .den_r   (dvp_den[k+1]),
      .rem_r   (dvp_rem[k+1]),
      .quo_r   (dvp_quo[k+1]),
      .pass_r  (dvp_pass[k+1])
    );
  end

  // s7: signed Q30 cosine terms
  function automatic logic signed [31:0] cos_term(input logic [2:0] flg,
                                                   input logic [QW-1:0] q);
    logic signed [31:0] c;
    if (flg[2]) begin
      c = ONE_Q30;
    end else if (flg[1]) begin
      c = -ONE_Q30;
    end else if (flg[0]) begin
      c = -$signed({2'b00, q});
    end else begin
      c = $signed({2'b00, q});
    end
    return c;
  endfunction

  logic signed [31:0] ck7_r, cp7_r;
  logic [41:0] xy7_r;

  always_ff @(posedge clk) begin
    ck7_r <= cos_term(dvk_pass[QW], dvk_quo[QW]);
    cp7_r <= cos_term(dvp_pass[QW][2:0], dvp_quo[QW]);
    xy7_r <= dvp_pass[QW][44:3];
  end

  // s8: c^2
  logic [31:0] ck_mag, cp_mag;
  logic [61:0] cksq8_r, cpsq8_r;
  logic signed [31:0] ck8_r, cp8_r;
  logic [41:0] xy8_r;

  assign ck_mag = ck7_r[31] ? -ck7_r : ck7_r;
  assign cp_mag = cp7_r[31] ? -cp7_r : cp7_r;

  always_ff @(posedge clk) begin
    cksq8_r <= ck_mag[30:0] * ck_mag[30:0];
    cpsq8_r <= cp_mag[30:0] * cp_mag[30:0];
    ck8_r   <= ck7_r;
    cp8_r   <= cp7_r;
    xy8_r   <= xy7_r;
  end

  // s9: 1 - c^2 radicands, start of sine root chains
  logic [R2_W-1:0]  sqk_rad [0:R2_RT];
  logic [R2_RT+1:0] sqk_rem [0:R2_RT];
  logic [R2_RT-1:0] sqk_root[0:R2_RT];
  logic [31:0]      sqk_pass[0:R2_RT];
  logic [R2_W-1:0]  sqp_rad [0:R2_RT];
  logic [R2_RT+1:0] sqp_rem [0:R2_RT];
  logic [R2_RT-1:0] sqp_root[0:R2_RT];
  logic [73:0]      sqp_pass[0:R2_RT];

  always_ff @(posedge clk) begin
    sqk_rad[0]  <= (62'd1 << 60) - cksq8_r;
    sqk_rem[0]  <= '0;
    sqk_root[0] <= '0;
    sqk_pass[0] <= ck8_r;
    sqp_rad[0]  <= (62'd1 << 60) - cpsq8_r;
    sqp_rem[0]  <= '0;
    sqp_root[0] <= '0;
    sqp_pass[0] <= {xy8_r, cp8_r};
  end

  // sine root chains
  for (genvar k = 0; k < R2_RT; k++) begin : g_sq2
    legik_sqrt_cell #(.RAD_W(R2_W), .PW(32)) u_knee (
      .clk     (clk),
      .rad_in  (sqk_rad[k]),
      .rem_in  (sqk_rem[k]),
      .root_in (sqk_root[k]),
      .pass_in (sqk_pass[k]),
      .rad_r   (sqk_rad[k+1]),
      .rem_r   (sqk_rem[k+1]),
      .root_r  (sqk_root[k+1]),
      .pass_r  (sqk_pass[k+1])
    );
    legik_sqrt_cell #(.RAD_W(R2_W), .PW(74)) u_hip (
      .clk     (clk),
      .rad_in  (sqp_rad[k]),
      .rem_in  (sqp_rem[k]),
      .root_in (sqp_root[k]),
      .pass_in (sqp_pass[k]),
      .rad_r   (sqp_rad[k+1]),
      .rem_r   (sqp_rem[k+1]),
      .root_r  (sqp_root[k+1]),
      .pass_r  (sqp_pass[k+1])
    );
  end

  // s10: CORDIC operands with quadrant pre-rotation
  logic signed [31:0] ck10, cp10;
  logic signed [20:0] x10, y10;
  logic signed [ANG_W-1:0] phi_ya, phi_xa;
  cordic_vec_t ak_vec[0:CORDIC_STAGES];
  cordic_vec_t ap_vec[0:CORDIC_STAGES];
  cordic_vec_t ph_vec[0:CORDIC_STAGES];
  logic [CORDIC_STAGES:0] zero_r;

  assign ck10   = sqk_pass[R2_RT];
  assign cp10   = sqp_pass[R2_RT][31:0];
  assign x10    = sqp_pass[R2_RT][73:53];
  assign y10    = sqp_pass[R2_RT][52:32];
  assign phi_ya = -$signed({{3{x10[20]}}, x10, 10'b0});
  assign phi_xa = $signed({{3{y10[20]}}, y10, 10'b0});

  always_ff @(posedge clk) begin
    ak_vec[0] <= cordic_prep($signed({3'b000, sqk_root[R2_RT]}),
                             $signed({{2{ck10[31]}}, ck10}));
    ap_vec[0] <= cordic_prep($signed({3'b000, sqp_root[R2_RT]}),
                             $signed({{2{cp10[31]}}, cp10}));
    ph_vec[0] <= cordic_prep(phi_ya, phi_xa);
    zero_r    <= {zero_r[CORDIC_STAGES-1:0], (x10 == '0) && (y10 == '0)};
  end

  // CORDIC chains
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    legik_cordic_cell #(.STAGE(k)) u_knee (
      .clk    (clk),
      .vec_in (ak_vec[k]),
      .vec_r  (ak_vec[k+1])
    );
    legik_cordic_cell #(.STAGE(k)) u_hip (
      .clk    (clk),
      .vec_in (ap_vec[k]),
      .vec_r  (ap_vec[k+1])
    );
    legik_cordic_cell #(.STAGE(k)) u_phi (
      .clk    (clk),
      .vec_in (ph_vec[k]),
      .vec_r  (ph_vec[k+1])
    );
  end

  // s11: angle sums with rounding offset
  logic signed [35:0] knee11_r, hip11_r;
  logic signed [ANG_W-1:0] phi_z;

  assign phi_z = zero_r[CORDIC_STAGES] ? '0 : ph_vec[CORDIC_STAGES].z;

  always_ff @(posedge clk) begin
    knee11_r <= 36'(PI_Q30) - 36'(ak_vec[CORDIC_STAGES].z) + 36'sd8192;
    hip11_r  <= 36'(phi_z) + 36'(ap_vec[CORDIC_STAGES].z) + 36'sd8192;
  end

  // s12: scale to 2^-16 rad and saturate
  logic signed [21:0] knee_s, hip_s;

  assign knee_s = 22'(knee11_r >>> 14);
  assign hip_s  = 22'(hip11_r >>> 14);

  always_ff @(posedge clk) begin
    if (knee_s[21]) begin
      out_knee_angle <= '0;
    end else if (knee_s > KNEE_MAX) begin
      out_knee_angle <= KNEE_MAX[17:0];
    end else begin
      out_knee_angle <= knee_s[17:0];
    end
    if (hip_s < HIP_MIN) begin
      out_hip_angle <= HIP_MIN[19:0];
    end else if (hip_s > HIP_MAX) begin
      out_hip_angle <= HIP_MAX[19:0];
    end else begin
      out_hip_angle <= hip_s[19:0];
    end
  end

  assign out_valid = vld_r[STAGES-1];

`ifndef SYNTHESIS
  // every transaction yields exactly one result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##STAGES out_valid)
    else $error("result missing after transaction");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, STAGES))
    else $error("result without a transaction");

  a_knee_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_knee_angle <= KNEE_MAX[17:0]))
    else $error("knee angle out of range");
`endif

endmodule
